/* src/ssrrip_pkg.sv */
// ssrrip_pkg: shared constants, types and state encoding for the replacement engine
// no dependencies; imported by ssrrip_ram users and the top level
package ssrrip_pkg;

    localparam int NUM_SETS    = 2048;   // power of two
    localparam int NUM_WAYS    = 16;
    localparam int SIG_BITS    = 6;

    localparam int SIG_ENTRIES = 1 << SIG_BITS;
    localparam int SET_AW      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_AW      = $clog2(NUM_WAYS);

    localparam int KIND_W      = 2;
    localparam int IN_SET_W    = 11;
    localparam int IN_WAY_W    = 4;
    localparam int ADDR_W      = 64;
    localparam int IN_SIG_W    = 6;
    localparam int MASK_W      = 16;
    localparam int VICTIM_W    = 4;

    localparam int CLR_DEPTH   = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
    localparam int CLR_AW      = $clog2(CLR_DEPTH);

    localparam int DECAY_PERIOD = 4096;
    localparam int TICK_W       = $clog2(DECAY_PERIOD);

    localparam logic [1:0] MAX_RRPV    = 2'd3;
    localparam logic [1:0] NORMAL_RRPV = 2'd2;
    localparam logic [1:0] MRU_RRPV    = 2'd0;
    localparam logic [1:0] CNT_MAX     = 2'd3;
    localparam logic [1:0] CNT_RESET   = 2'd1;
    localparam logic [1:0] LEVEL_MAX   = 2'd3;
    localparam logic [1:0] LEVEL_STREAM = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_VICTIM = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_CNT1,
        ST_CNT2,
        ST_HB_RD,
        ST_HB_WR,
        ST_DC_RD,
        ST_DC_WR
    } state_t;

    // one row of the set memory holds everything kept per set
    typedef struct packed {
        logic [NUM_WAYS-1:0][1:0]          rrpv;
        logic [NUM_WAYS-1:0][SIG_BITS-1:0] sig;
        logic [ADDR_W-1:0]                 prev_addr;
        logic [ADDR_W-1:0]                 prev_stride;
        logic [1:0]                        level;
    } set_row_t;

    localparam int ROW_W = $bits(set_row_t);

endpackage

/* src/ssrrip_ram.sv */
// ssrrip_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module ssrrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/ship_stream_rrip_replacement.sv */
// ship_stream_rrip_replacement: srrip victim selection with signature reuse counters and stride streams
// depends on ssrrip_pkg and ssrrip_ram
//
// After reset the block runs a clearing pass over max(NUM_SETS, SIG_ENTRIES) entries (2048 here)
// with item_ready low. Every item then goes through the single port pair of the set-row memory
// and the signature-counter memory under a small sequencer, one item at a time. A victim query
// reads the row, then picks and ages; an access update reads the row, then increments the
// signature counter on a hit, or decrements the old line's counter and reads the new one on a fill;
// a heartbeat tick walks every set row, plus the counter decay walk on every 4096th tick.
// A victim result sits in an output register; a second query waits for it.
module ship_stream_rrip_replacement
    import ssrrip_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [IN_SET_W-1:0] set_index,
    input  logic [IN_WAY_W-1:0] way,
    input  logic [ADDR_W-1:0]   address,
    input  logic [IN_SIG_W-1:0] signature,
    input  logic                hit,
    input  logic [MASK_W-1:0]   valid_mask,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [VICTIM_W-1:0] victim_way
);

    state_t state_reg, state_next;

    kind_t                kind_reg, kind_next;
    logic [SET_AW-1:0]    set_reg, set_next;
    logic [WAY_AW-1:0]    way_reg, way_next;
    logic                 way_ok_reg, way_ok_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [SIG_BITS-1:0]  sig_reg, sig_next;
    logic                 hit_reg, hit_next;
    logic [MASK_W-1:0]    mask_reg, mask_next;
    set_row_t             row_reg, row_next;
    logic [SIG_BITS-1:0]  old_sig_reg, old_sig_next;
    logic [1:0]           fwd_reg, fwd_next;
    logic [CLR_AW-1:0]    idx_reg, idx_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic                 result_valid_reg, result_valid_next;
    logic [VICTIM_W-1:0]  victim_way_reg, victim_way_next;

    // memory ports
    logic                 row_we, row_re;
    logic [SET_AW-1:0]    row_waddr, row_raddr;
    logic [ROW_W-1:0]     row_wdata, row_rdata;
    logic                 cnt_we, cnt_re;
    logic [SIG_BITS-1:0]  cnt_waddr, cnt_raddr;
    logic [1:0]           cnt_wdata, cnt_rdata;

    ssrrip_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    ssrrip_ram #(.WIDTH(2), .DEPTH(SIG_ENTRIES)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // input decode
    logic                         take;
    logic [SET_AW+IN_SET_W-1:0]   in_set_ext;
    logic [SET_AW-1:0]            in_set;
    logic [5:0]                   in_way_ext;
    logic [IN_SIG_W+SIG_BITS-1:0] in_sig_ext;

    assign item_ready = (state_reg == ST_IDLE);
    assign take       = item_valid && item_ready;
    assign in_set_ext = (SET_AW+IN_SET_W)'(set_index);
    assign in_set     = in_set_ext[SET_AW-1:0];
    assign in_way_ext = 6'(way);
    assign in_sig_ext = (IN_SIG_W+SIG_BITS)'(signature);

    // walk counters
    logic last_set, last_sig, last_clr, clr_row, clr_cnt;

    assign last_set = (idx_reg == CLR_AW'(NUM_SETS - 1));
    assign last_sig = (idx_reg == CLR_AW'(SIG_ENTRIES - 1));
    assign last_clr = (idx_reg == CLR_AW'(CLR_DEPTH - 1));
    assign clr_row  = ({1'b0, idx_reg} < (CLR_AW+1)'(NUM_SETS));
    assign clr_cnt  = ({1'b0, idx_reg} < (CLR_AW+1)'(SIG_ENTRIES));

    // row evaluation
    set_row_t             row_rd, row_upd, row_aged;
    logic [ADDR_W-1:0]    stride;
    logic                 stream_match;
    logic [1:0]           level_new;
    logic [MASK_W+NUM_WAYS-1:0] valid_ext;
    logic [NUM_WAYS-1:0]  way_valid;
    logic [NUM_WAYS-1:0]  is3, is2, is1, is_max;
    logic                 any_invalid;
    logic [WAY_AW-1:0]    first_invalid, first_max, pick;
    logic [WAY_AW+VICTIM_W-1:0] pick_ext;
    logic [1:0]           max_rrpv, age_add;
    logic                 out_free;

    assign row_rd       = set_row_t'(row_rdata);
    assign stride       = addr_reg - row_rd.prev_addr;
    assign stream_match = (row_rd.prev_addr != '0) && (stride == row_rd.prev_stride);
    assign valid_ext    = {{NUM_WAYS{1'b1}}, mask_reg};
    assign way_valid    = valid_ext[NUM_WAYS-1:0];
    assign out_free     = !result_valid_reg || result_ready;

    always_comb
    begin
        if (stream_match)
        begin
            level_new = (row_rd.level < LEVEL_MAX) ? row_rd.level + 2'd1 : row_rd.level;
        end
        else
        begin
            level_new = (row_rd.level != 2'd0) ? row_rd.level - 2'd1 : row_rd.level;
        end
        row_upd             = row_rd;
        row_upd.prev_addr   = addr_reg;
        row_upd.prev_stride = stride;
        row_upd.level       = level_new;
    end

    // lowest invalid way, else lowest way holding the top rrpv (it reaches 3 after aging)
    always_comb
    begin
        any_invalid   = 1'b0;
        first_invalid = '0;
        first_max     = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            is3[w] = (row_rd.rrpv[w] == 2'd3);
            is2[w] = (row_rd.rrpv[w] == 2'd2);
            is1[w] = (row_rd.rrpv[w] == 2'd1);
        end
        if (|is3)
        begin
            max_rrpv = 2'd3;
        end
        else if (|is2)
        begin
            max_rrpv = 2'd2;
        end
        else if (|is1)
        begin
            max_rrpv = 2'd1;
        end
        else
        begin
            max_rrpv = 2'd0;
        end
        age_add  = MAX_RRPV - max_rrpv;
        row_aged = row_rd;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            is_max[w]        = (row_rd.rrpv[w] == max_rrpv);
            row_aged.rrpv[w] = row_rd.rrpv[w] + age_add;
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (!way_valid[w])
            begin
                any_invalid   = 1'b1;
                first_invalid = WAY_AW'(w);
            end
            if (is_max[w])
            begin
                first_max = WAY_AW'(w);
            end
        end
        pick = any_invalid ? first_invalid : first_max;
    end

    assign pick_ext = (WAY_AW+VICTIM_W)'(pick);

    // counter arithmetic
    logic       dec_old;
    logic [1:0] cnt_sig;
    logic [1:0] fill_rrpv;

    assign dec_old   = (old_sig_reg != '0) && (cnt_rdata != 2'd0);
    // the read of the new signature raced the decrement of the old one
    assign cnt_sig   = (sig_reg == old_sig_reg) ? fwd_reg : cnt_rdata;
    assign fill_rrpv = ((row_reg.level >= LEVEL_STREAM) || (cnt_sig <= 2'd1)) ?
                       MAX_RRPV : NORMAL_RRPV;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (last_clr)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    case (kind_t'(kind))
                        KIND_VICTIM: state_next = ST_EVAL;
                        KIND_UPDATE: state_next = ST_EVAL;
                        KIND_TICK:   state_next = ST_HB_RD;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EVAL:
            begin
                if (kind_reg == KIND_VICTIM)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!way_ok_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CNT1;
                end
            end
            ST_CNT1:
            begin
                state_next = hit_reg ? ST_IDLE : ST_CNT2;
            end
            ST_CNT2:
            begin
                state_next = ST_IDLE;
            end
            ST_HB_RD:
            begin
                state_next = ST_HB_WR;
            end
            ST_HB_WR:
            begin
                if (!last_set)
                begin
                    state_next = ST_HB_RD;
                end
                else if (tick_reg == '1)
                begin
                    state_next = ST_DC_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DC_RD:
            begin
                state_next = ST_DC_WR;
            end
            ST_DC_WR:
            begin
                state_next = last_sig ? ST_IDLE : ST_DC_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        kind_next         = kind_reg;
        set_next          = set_reg;
        way_next          = way_reg;
        way_ok_next       = way_ok_reg;
        addr_next         = addr_reg;
        sig_next          = sig_reg;
        hit_next          = hit_reg;
        mask_next         = mask_reg;
        row_next          = row_reg;
        old_sig_next      = old_sig_reg;
        fwd_next          = fwd_reg;
        idx_next          = idx_reg;
        tick_next         = tick_reg;
        victim_way_next   = victim_way_reg;
        result_valid_next = result_valid_reg && !result_ready;

        row_we    = 1'b0;
        row_waddr = set_reg;
        row_wdata = ROW_W'(row_reg);
        row_re    = 1'b0;
        row_raddr = in_set;
        cnt_we    = 1'b0;
        cnt_waddr = sig_reg;
        cnt_wdata = cnt_rdata;
        cnt_re    = 1'b0;
        cnt_raddr = sig_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                row_we    = clr_row;
                row_waddr = idx_reg[SET_AW-1:0];
                row_wdata = '0;
                cnt_we    = clr_cnt;
                cnt_waddr = idx_reg[SIG_BITS-1:0];
                cnt_wdata = CNT_RESET;
                idx_next  = last_clr ? '0 : idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    kind_next   = kind_t'(kind);
                    set_next    = in_set;
                    way_next    = in_way_ext[WAY_AW-1:0];
                    way_ok_next = (in_way_ext < 6'(NUM_WAYS));
                    addr_next   = address;
                    sig_next    = in_sig_ext[SIG_BITS-1:0];
                    hit_next    = hit;
                    mask_next   = valid_mask;
                    row_re      = 1'b1;
                    idx_next    = '0;
                end
            end
            ST_EVAL:
            begin
                if (kind_reg == KIND_VICTIM)
                begin
                    if (out_free)
                    begin
                        result_valid_next = 1'b1;
                        victim_way_next   = pick_ext[VICTIM_W-1:0];
                        row_we            = !any_invalid;
                        row_wdata         = ROW_W'(row_aged);
                    end
                end
                else if (!way_ok_reg)
                begin
                    row_we    = 1'b1;
                    row_wdata = ROW_W'(row_upd);
                end
                else if (hit_reg)
                begin
                    row_next               = row_upd;
                    row_next.rrpv[way_reg] = MRU_RRPV;
                    cnt_re                 = 1'b1;
                    cnt_raddr              = sig_reg;
                end
                else
                begin
                    row_next              = row_upd;
                    row_next.sig[way_reg] = sig_reg;
                    old_sig_next          = row_rd.sig[way_reg];
                    cnt_re                = 1'b1;
                    cnt_raddr             = row_rd.sig[way_reg];
                end
            end
            ST_CNT1:
            begin
                if (hit_reg)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = sig_reg;
                    cnt_wdata = (cnt_rdata < CNT_MAX) ? cnt_rdata + 2'd1 : cnt_rdata;
                    row_we    = 1'b1;
                    row_wdata = ROW_W'(row_reg);
                end
                else
                begin
                    cnt_we    = dec_old;
                    cnt_waddr = old_sig_reg;
                    cnt_wdata = cnt_rdata - 2'd1;
                    fwd_next  = dec_old ? cnt_rdata - 2'd1 : cnt_rdata;
                    cnt_re    = 1'b1;
                    cnt_raddr = sig_reg;
                end
            end
            ST_CNT2:
            begin
                row_next               = row_reg;
                row_next.rrpv[way_reg] = fill_rrpv;
                row_we                 = 1'b1;
                row_wdata              = ROW_W'(row_next);
            end
            ST_HB_RD:
            begin
                row_re    = 1'b1;
                row_raddr = idx_reg[SET_AW-1:0];
            end
            ST_HB_WR:
            begin
                row_next       = row_rd;
                row_next.level = (row_rd.level != 2'd0) ? row_rd.level - 2'd1 : row_rd.level;
                row_we         = 1'b1;
                row_waddr      = idx_reg[SET_AW-1:0];
                row_wdata      = ROW_W'(row_next);
                if (last_set)
                begin
                    idx_next  = '0;
                    tick_next = tick_reg + 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DC_RD:
            begin
                cnt_re    = 1'b1;
                cnt_raddr = idx_reg[SIG_BITS-1:0];
            end
            ST_DC_WR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = idx_reg[SIG_BITS-1:0];
                cnt_wdata = (cnt_rdata > 2'd1) ? cnt_rdata - 2'd1 : cnt_rdata;
                idx_next  = last_sig ? '0 : idx_reg + 1'b1;
            end
            default:
            begin
                row_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            idx_reg          <= '0;
            tick_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            tick_reg         <= tick_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        set_reg        <= set_next;
        way_reg        <= way_next;
        way_ok_reg     <= way_ok_next;
        addr_reg       <= addr_next;
        sig_reg        <= sig_next;
        hit_reg        <= hit_next;
        mask_reg       <= mask_next;
        row_reg        <= row_next;
        old_sig_reg    <= old_sig_next;
        fwd_reg        <= fwd_next;
        victim_way_reg <= victim_way_next;
    end

    assign result_valid = result_valid_reg;
    assign victim_way   = victim_way_reg;

    // a result only appears out of the evaluation step of a victim query
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_EVAL && kind_reg == KIND_VICTIM))
        else $error("result raised outside a victim query");

    // the second counter step belongs to a fill only
    a_cnt2_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CNT2 |-> $past(state_reg) == ST_CNT1 && !hit_reg)
        else $error("second counter step without a fill");

    // finishing the set walk counts exactly one tick
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HB_WR && last_set) |=> tick_reg == $past(tick_reg) + 1'b1)
        else $error("tick count not advanced after the set walk");

    // an out-of-range way only touches the stream fields and ends the update
    a_bad_way: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && kind_reg == KIND_UPDATE && !way_ok_reg) |=>
        state_reg == ST_IDLE)
        else $error("update with out-of-range way did not finish");

endmodule

/* dv/replacement_shadow_pkg.sv */
// replacement_shadow_pkg: shadow copy of the rrip replacement state and the victim scoreboard
// depends on ssrrip_pkg for sizes, kinds and rrpv constants
package replacement_shadow_pkg;

    import ssrrip_pkg::*;

    class replacement_shadow;
        bit [1:0]          rrpv        [NUM_SETS][NUM_WAYS];
        bit [SIG_BITS-1:0] line_sig    [NUM_SETS][NUM_WAYS];
        bit [ADDR_W-1:0]   prev_addr   [NUM_SETS];
        bit [ADDR_W-1:0]   last_stride [NUM_SETS];
        bit [1:0]          level       [NUM_SETS];
        bit [1:0]          reuse       [SIG_ENTRIES];
        bit [TICK_W-1:0]   ticks;
        bit [VICTIM_W-1:0] expected_victims [$];
        int                mismatches;

        function new();
            foreach (reuse[i])
                reuse[i] = CNT_RESET;
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] victim mismatch: %s", $realtime, msg);
        endfunction

        function void advance_stream(int s, bit [ADDR_W-1:0] a);
            bit [ADDR_W-1:0] stride;
            stride = a - prev_addr[s];
            // a zero previous address never counts as a stride match
            if (prev_addr[s] != 0 && stride == last_stride[s])
            begin
                if (level[s] != LEVEL_MAX)
                    level[s]++;
            end
            else if (level[s] != 0)
                level[s]--;
            last_stride[s] = stride;
            prev_addr[s]   = a;
        endfunction

        function bit [VICTIM_W-1:0] pick_victim(int s, bit [MASK_W-1:0] mask);
            bit [1:0] top;
            top = 0;
            for (int w = 0; w < NUM_WAYS; w++)
                if (!mask[w])
                    return VICTIM_W'(w);
            for (int w = 0; w < NUM_WAYS; w++)
                if (rrpv[s][w] > top)
                    top = rrpv[s][w];
            // age the whole row so the oldest line lands on max rrpv
            if (top < MAX_RRPV)
                for (int w = 0; w < NUM_WAYS; w++)
                    rrpv[s][w] = rrpv[s][w] + (MAX_RRPV - top);
            for (int w = 0; w < NUM_WAYS; w++)
                if (rrpv[s][w] == MAX_RRPV)
                    return VICTIM_W'(w);
            return 0;
        endfunction

        function void update_line(int s, int w, bit [ADDR_W-1:0] a, bit [SIG_BITS-1:0] sig,
                                  bit is_hit);
            bit [SIG_BITS-1:0] old_sig;
            advance_stream(s, a);
            if (is_hit)
            begin
                rrpv[s][w] = MRU_RRPV;
                if (reuse[sig] < CNT_MAX)
                    reuse[sig]++;
                return;
            end
            old_sig = line_sig[s][w];
            if (old_sig != 0 && reuse[old_sig] > 0)
                reuse[old_sig]--;
            line_sig[s][w] = sig;
            if (level[s] >= LEVEL_STREAM || reuse[sig] <= CNT_RESET)
                rrpv[s][w] = MAX_RRPV;
            else
                rrpv[s][w] = NORMAL_RRPV;
        endfunction

        function void heartbeat();
            foreach (level[i])
                if (level[i] != 0)
                    level[i]--;
            ticks++;
            if (ticks == 0)
                foreach (reuse[i])
                    if (reuse[i] > CNT_RESET)
                        reuse[i]--;
        endfunction

        function void note_item(kind_t k, bit [IN_SET_W-1:0] s, bit [IN_WAY_W-1:0] w,
                                bit [ADDR_W-1:0] a, bit [IN_SIG_W-1:0] sig, bit is_hit,
                                bit [MASK_W-1:0] mask);
            case (k)
                KIND_VICTIM: expected_victims.push_back(pick_victim(s, mask));
                KIND_UPDATE: update_line(s, w, a, sig, is_hit);
                KIND_TICK:   heartbeat();
                default:     ;
            endcase
        endfunction

        function void check_victim(bit [VICTIM_W-1:0] got);
            bit [VICTIM_W-1:0] want;
            if (expected_victims.size() == 0)
            begin
                flag_error($sformatf("unexpected victim way %0d", got));
                return;
            end
            want = expected_victims.pop_front();
            if (want != got)
                flag_error($sformatf("expected way %0d, got %0d", want, got));
        endfunction
    endclass

endpackage

/* dv/tb_top.sv */
// tb_top: drives random and directed queries, updates and ticks into the replacement engine
// depends on ssrrip_pkg, replacement_shadow_pkg and ship_stream_rrip_replacement
module tb_top;

    import ssrrip_pkg::*;
    import replacement_shadow_pkg::*;

    localparam int RUN_ITEMS    = 850;
    localparam int CALM_ITEMS   = 150;
    localparam int MAX_TICKS    = 20;
    localparam int CYCLE_LIMIT  = 1_000_000;
    // longest single item: a tick that also walks the counters
    localparam int DRAIN_CYCLES = 2 * NUM_SETS + 2 * SIG_ENTRIES + 64;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    logic [KIND_W-1:0]   kind;
    logic [IN_SET_W-1:0] set_index;
    logic [IN_WAY_W-1:0] way;
    logic [ADDR_W-1:0]   address;
    logic [IN_SIG_W-1:0] signature;
    logic                hit;
    logic [MASK_W-1:0]   valid_mask;
    logic                result_valid;
    logic                result_ready;
    logic [VICTIM_W-1:0] victim_way;

    replacement_shadow shadow;
    int                idle_pct    = 30;
    int                stall_left  = 0;
    int                cycle_count = 0;
    int                sent        = 0;
    int                ticks_sent  = 0;
    int                hot_sets    [8];
    bit [ADDR_W-1:0]   stream_next [8];
    bit [IN_SIG_W-1:0] sig_pool    [6];

    ship_stream_rrip_replacement dut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                shadow.check_victim(victim_way);
            if (item_valid && item_ready)
                shadow.note_item(kind_t'(kind), set_index, way, address, signature, hit,
                                 valid_mask);
        end
    end

    // result back-pressure in short random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready = 1'b0;
            stall_left--;
        end
        else
        begin
            result_ready = 1'b1;
            if ($urandom_range(0, 99) < idle_pct)
                stall_left = $urandom_range(1, 3);
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(kind_t k, bit [IN_SET_W-1:0] s, bit [IN_WAY_W-1:0] w,
                             bit [ADDR_W-1:0] a, bit [IN_SIG_W-1:0] sg, bit h,
                             bit [MASK_W-1:0] m);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        kind       = k;
        set_index  = s;
        way        = w;
        address    = a;
        signature  = sg;
        hit        = h;
        valid_mask = m;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
        if (k != KIND_NONE)
            sent++;
        if (k == KIND_TICK)
            ticks_sent++;
    endtask

    task automatic send_update(int s, bit [ADDR_W-1:0] a);
        bit [IN_SIG_W-1:0] sg;
        sg = ($urandom_range(0, 3) == 0) ? IN_SIG_W'($urandom) : sig_pool[$urandom_range(0, 5)];
        send_item(KIND_UPDATE, IN_SET_W'(s), IN_WAY_W'($urandom_range(0, NUM_WAYS - 1)), a, sg,
                  $urandom_range(0, 99) < 40, MASK_W'($urandom));
    endtask

    task automatic send_query(int s);
        bit [MASK_W-1:0] m;
        int              pick;
        pick = $urandom_range(0, 9);
        m    = '1;
        if (pick >= 8)
            m = MASK_W'($urandom);
        else if (pick >= 6)
            m[WAY_AW'($urandom_range(0, NUM_WAYS - 1))] = 1'b0;
        send_item(KIND_VICTIM, IN_SET_W'(s), IN_WAY_W'($urandom_range(0, NUM_WAYS - 1)),
                  {$urandom, $urandom}, IN_SIG_W'($urandom), 1'($urandom_range(0, 1)), m);
    endtask

    initial
    begin
        int              choice;
        int              slot;
        int              len;
        bit              paused;
        bit [ADDR_W-1:0] stride;

        shadow     = new();
        rst_n      = 1'b0;
        item_valid = 1'b0;
        kind       = KIND_NONE;
        set_index  = '0;
        way        = '0;
        address    = '0;
        signature  = '0;
        hit        = 1'b0;
        valid_mask = '0;
        paused     = 1'b0;
        foreach (hot_sets[i])
        begin
            hot_sets[i]    = $urandom_range(0, NUM_SETS - 1);
            stream_next[i] = {$urandom, $urandom};
        end
        hot_sets[0] = 0;
        hot_sets[1] = NUM_SETS - 1;
        foreach (sig_pool[i])
            sig_pool[i] = IN_SIG_W'($urandom);
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty and full masks, all-max aging, wrapping stride, zero previous address
        send_item(KIND_VICTIM, 0, 0, 0, 0, 0, 16'h0000);
        send_item(KIND_VICTIM, 11'h7FF, 4'hF, '1, '1, 1, 16'hFFFF);
        send_item(KIND_VICTIM, 5, 0, 0, 0, 0, 16'h7FFF);
        send_item(KIND_UPDATE, 11'h7FF, 4'hF, '1, 6'h3F, 0, 16'h0000);
        send_item(KIND_UPDATE, 11'h7FF, 4'hF, 0, 6'h3F, 1, 16'hFFFF);
        send_item(KIND_VICTIM, 11'h7FF, 0, 0, 0, 0, 16'hFFFF);
        send_item(KIND_UPDATE, 9, 0, 0, 0, 0, 16'hFFFF);
        send_item(KIND_UPDATE, 9, 1, 0, 1, 0, 16'hFFFF);
        for (int k = 0; k < 5; k++)
            send_item(KIND_UPDATE, 7, IN_WAY_W'(k), 64'h1000 + 64'h40 * k, 5, 0, 16'hFFFF);
        send_item(KIND_UPDATE, 7, 2, 64'h9000, 5, 1, 16'hFFFF);
        send_item(KIND_UPDATE, 7, 3, 64'h9100, 5, 1, 16'hFFFF);
        send_item(KIND_UPDATE, 8, 0, 64'h20, 5, 0, 16'hFFFF);
        send_item(KIND_UPDATE, 8, 0, 64'h80, 6, 0, 16'hFFFF);
        send_item(KIND_VICTIM, 7, 0, 0, 0, 0, 16'hFFFF);
        send_item(KIND_VICTIM, 8, 0, 0, 0, 0, 16'hFFFF);
        send_item(KIND_TICK, 3, 7, {$urandom, $urandom}, 6'h2A, 1, 16'h5A5A);
        send_item(KIND_NONE, 7, 3, {$urandom, $urandom}, 6'h15, 0, 16'h0000);
        send_item(KIND_VICTIM, 7, 0, 0, 0, 0, 16'hFFFF);

        while (sent < RUN_ITEMS)
        begin
            idle_pct = (sent >= RUN_ITEMS - CALM_ITEMS || (sent / 100) % 3 == 2) ? 0 : 30;
            if (!paused && sent >= RUN_ITEMS / 2)
            begin
                // hold the sender until all victims are back
                paused     = 1'b1;
                item_valid = 1'b0;
                while (shadow.expected_victims.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            choice = $urandom_range(0, 99);
            slot   = $urandom_range(0, 7);
            if (choice < 55)
            begin
                // constant-stride run on one set, sometimes broken by queries
                case ($urandom_range(0, 3))
                    0:       stride = 64'd64;
                    1:       stride = 64'd4096;
                    2:       stride = -64'sd64;
                    default: stride = {$urandom, $urandom};
                endcase
                len = $urandom_range(3, 8);
                for (int k = 0; k < len; k++)
                begin
                    send_update(hot_sets[slot], stream_next[slot]);
                    stream_next[slot] += stride;
                    if ($urandom_range(0, 9) < 3)
                        send_query(hot_sets[slot]);
                end
            end
            else if (choice < 85)
                send_query(hot_sets[slot]);
            else if (choice < 95)
                send_update($urandom_range(0, NUM_SETS - 1), {$urandom, $urandom});
            else if (choice < 98 && ticks_sent < MAX_TICKS)
                send_item(KIND_TICK, IN_SET_W'($urandom_range(0, NUM_SETS - 1)),
                          IN_WAY_W'($urandom_range(0, 15)), {$urandom, $urandom},
                          IN_SIG_W'($urandom), 1'($urandom_range(0, 1)), MASK_W'($urandom));
            else
                send_item(KIND_NONE, IN_SET_W'($urandom_range(0, NUM_SETS - 1)),
                          IN_WAY_W'($urandom_range(0, 15)), {$urandom, $urandom},
                          IN_SIG_W'($urandom), 1'($urandom_range(0, 1)), MASK_W'($urandom));
        end

        item_valid = 1'b0;
        while (shadow.expected_victims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.expected_victims.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
src/ssrrip_pkg.sv
src/ssrrip_ram.sv
src/ship_stream_rrip_replacement.sv
dv/replacement_shadow_pkg.sv
dv/tb_top.sv
